[rtl/core/grid_neighbor_type_counter_macros.svh]
// Assertion macros shared by the grid neighbor counter RTL.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef GRID_NEIGHBOR_TYPE_COUNTER_MACROS_SVH
`define GRID_NEIGHBOR_TYPE_COUNTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GNTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define GNTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/gntc_pkg.sv]
// Shared types, constants and offset tables for the grid neighbor counter.
// No dependencies; imported by every module of the block.
package gntc_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int SIZE_W     = 7;
  localparam int TYPE_W     = 2;
  localparam int CNT_W      = 4;
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int MEM_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int NBR_W      = 3;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOORE_MODE    = 2'd3;

  localparam logic [1:0] BND_NONE   = 2'd0;
  localparam logic [1:0] BND_CLOSED = 2'd1;
  localparam logic [1:0] BND_TORUS  = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [TYPE_W-1:0] CELL_EMPTY = 2'd0;

  localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd64;
  localparam logic [SIZE_W-1:0] COLS_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY_ZERO,
    OP_QUERY_SCAN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [TYPE_W-1:0]  cell_type;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic              wrap;
    logic              moore;
  } cfg_t;

  typedef enum logic [1:0] {
    DIR_MINUS,
    DIR_ZERO,
    DIR_PLUS
  } dir_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_FLUSH,
    B_DONE
  } back_state_t;

  // Neighbor offsets: four orthogonal first, then the diagonals.
  localparam dir_t OFF_R [8] = '{DIR_MINUS, DIR_PLUS, DIR_ZERO, DIR_ZERO,
                                 DIR_MINUS, DIR_MINUS, DIR_PLUS, DIR_PLUS};
  localparam dir_t OFF_C [8] = '{DIR_ZERO, DIR_ZERO, DIR_MINUS, DIR_PLUS,
                                 DIR_MINUS, DIR_PLUS, DIR_MINUS, DIR_PLUS};

  // Zero reads as one, anything above the limit saturates.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v == '0) res = SIZE_W'(1);
    else if (v > lim) res = lim;
    return res;
  endfunction

endpackage

[rtl/core/grid_neighbor_type_counter.sv]
// Grid neighbor type counter. Back end handles a write, a zero-count query, or a scanning query
// of up to 4 or 8 single-port memory reads (Moore mode sets 8), one item at a time;
// a 2-entry queue decouples input.
// Reset (rst, synchronous) restores register defaults and runs a clear pass over all
// 4096 grid memory entries, during which s_tready stays low; config writes still land.
module grid_neighbor_type_counter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gntc_pkg::S_TDATA_W-1:0]   s_tdata,   // row[5:0], col[11:6], cell_type[13:12]
  input  logic                             s_tuser,   // kind
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gntc_pkg::M_TDATA_W-1:0]   m_tdata,   // empty, o, x, k, occupied: 4 bits each
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gntc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gntc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gntc_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  logic clear_done;

  gntc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept_en (clear_done),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .cfg       (cfg)
  );

  gntc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  gntc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .empty      (q_empty),
    .head       (head),
    .pop        (pop),
    .clear_done (clear_done),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

[rtl/core/gntc_front.sv]
// Front end: configuration registers, input accept and item classification.
// Depends on gntc_pkg; feeds gntc_queue and exports the clamped configuration.
module gntc_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gntc_pkg::S_TDATA_W-1:0]   s_tdata,   // row[5:0], col[11:6], cell_type[13:12]
  input  logic                             s_tuser,   // kind
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gntc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gntc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             accept_en,
  input  logic                             q_full,
  output logic                             push,
  output gntc_pkg::cmd_t                   push_cmd,
  output gntc_pkg::cfg_t                   cfg
);
  import gntc_pkg::*;

  logic [SIZE_W-1:0] row_count;
  logic [SIZE_W-1:0] col_count;
  logic [1:0]        boundary_mode;
  logic              moore_mode;

  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic              in_grid;
  logic              beat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= ROWS_RESET;
      col_count     <= COLS_RESET;
      boundary_mode <= BND_CLOSED;
      moore_mode    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:     row_count     <= cfg_data;
        CFG_COL_COUNT:     col_count     <= cfg_data;
        CFG_BOUNDARY_MODE: boundary_mode <= cfg_data[1:0];
        CFG_MOORE_MODE:    moore_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.rows  = clamp_size(row_count, SIZE_W'(MAX_ROWS));
  assign cfg.cols  = clamp_size(col_count, SIZE_W'(MAX_COLS));
  assign cfg.wrap  = (boundary_mode == BND_TORUS);
  assign cfg.moore = moore_mode;

  assign in_row   = s_tdata[ROW_W-1:0];
  assign in_col   = s_tdata[ROW_W +: COL_W];
  assign in_grid  = ({1'b0, in_row} < cfg.rows) && ({1'b0, in_col} < cfg.cols);
  assign s_tready = accept_en && !q_full;
  assign beat     = s_tvalid && s_tready;

  always_comb begin
    push_cmd.row       = in_row;
    push_cmd.col       = in_col;
    push_cmd.cell_type = s_tdata[ROW_W+COL_W +: TYPE_W];
    if (s_tuser == KIND_WRITE) begin
      push_cmd.op = OP_WRITE;
    end else if (in_grid && (boundary_mode == BND_CLOSED || boundary_mode == BND_TORUS)) begin
      push_cmd.op = OP_QUERY_SCAN;
    end else begin
      push_cmd.op = OP_QUERY_ZERO;
    end
    // Drop writes that land outside the grid in use.
    push = beat && !(s_tuser == KIND_WRITE && !in_grid);
  end

endmodule

[rtl/core/gntc_queue.sv]
// Short command queue between the front end and the back end.
// Depends on gntc_pkg for the command type and depth.
module gntc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gntc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output gntc_pkg::cmd_t head
);
  import gntc_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

[rtl/core/gntc_back.sv]
// Back end: grid memory, clear pass, neighbor scan sequencer and result register.
// Depends on gntc_pkg and the assertion macros header.
module gntc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  gntc_pkg::cfg_t                  cfg,
  input  logic                            empty,
  input  gntc_pkg::cmd_t                  head,
  output logic                            pop,
  output logic                            clear_done,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gntc_pkg::M_TDATA_W-1:0]  m_tdata
);
  import gntc_pkg::*;
  `include "grid_neighbor_type_counter_macros.svh"

  logic [TYPE_W-1:0] mem [MEM_DEPTH];
  logic [TYPE_W-1:0] rdata;

  back_state_t state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [NBR_W-1:0]  nbr;
  logic              rd_pend;
  logic [CNT_W-1:0]  cnt [4];

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [TYPE_W-1:0] mem_wdata;
  logic              rd_issue;
  logic              cnt_clear;
  logic              out_load;
  logic              out_free;
  logic              nbr_last;

  logic [ROW_W-1:0]  nr;
  logic [COL_W-1:0]  nc;
  logic              at_edge;
  logic              skip;

  assign out_free   = !m_tvalid || m_tready;
  assign clear_done = (state != B_CLEAR);
  assign nbr_last   = cfg.moore ? (nbr == NBR_W'(7)) : (nbr == NBR_W'(3));

  // Neighbor position for the current offset, wrapped or flagged at an edge.
  always_comb begin
    at_edge = 1'b0;
    nr = head.row;
    nc = head.col;
    case (OFF_R[nbr])
      DIR_MINUS: begin
        if (head.row == '0) begin
          at_edge = 1'b1;
          nr = ROW_W'(cfg.rows - 1'b1);
        end else begin
          nr = head.row - 1'b1;
        end
      end
      DIR_PLUS: begin
        if (({1'b0, head.row} + 1'b1) == cfg.rows) begin
          at_edge = 1'b1;
          nr = '0;
        end else begin
          nr = head.row + 1'b1;
        end
      end
      default: ;
    endcase
    case (OFF_C[nbr])
      DIR_MINUS: begin
        if (head.col == '0) begin
          at_edge = 1'b1;
          nc = COL_W'(cfg.cols - 1'b1);
        end else begin
          nc = head.col - 1'b1;
        end
      end
      DIR_PLUS: begin
        if (({1'b0, head.col} + 1'b1) == cfg.cols) begin
          at_edge = 1'b1;
          nc = '0;
        end else begin
          nc = head.col + 1'b1;
        end
      end
      default: ;
    endcase
    skip = at_edge && !cfg.wrap;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) state_next = B_IDLE;
      B_IDLE: begin
        if (!empty) begin
          unique case (head.op)
            OP_QUERY_SCAN: state_next = B_SCAN;
            OP_QUERY_ZERO: state_next = B_DONE;
            default:       state_next = B_IDLE;
          endcase
        end
      end
      B_SCAN:  if (nbr_last) state_next = B_FLUSH;
      B_FLUSH: state_next = B_DONE;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {nr, nc};
    mem_wdata = head.cell_type;
    rd_issue  = 1'b0;
    cnt_clear = 1'b0;
    out_load  = 1'b0;
    pop       = 1'b0;
    unique case (state)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = CELL_EMPTY;
      end
      B_IDLE: begin
        cnt_clear = 1'b1;
        if (!empty && head.op == OP_WRITE) begin
          mem_we   = 1'b1;
          mem_addr = {head.row, head.col};
          pop      = 1'b1;
        end
      end
      B_SCAN: rd_issue = !skip;
      B_DONE: begin
        out_load = out_free;
        pop      = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    else        rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      nbr      <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_issue;
      if (state == B_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == B_SCAN) nbr <= nbr + 1'b1;
      else                 nbr <= '0;
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Tally the cell read in the previous cycle.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (cnt_clear)                              cnt[i] <= '0;
      else if (rd_pend && rdata == TYPE_W'(i))    cnt[i] <= cnt[i] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0000, CNT_W'(cnt[1] + cnt[2] + cnt[3]),
                  cnt[3], cnt[2], cnt[1], cnt[0]};
    end
  end

  `GNTC_ASSERT_IMP(a_pop_nonempty, pop, !empty, "pop from an empty queue")
  `GNTC_ASSERT_IMP(a_load_free, out_load, out_free, "result overwrites a pending beat")
  `GNTC_ASSERT_IMP(a_rd_in_scan, rd_pend, state == B_SCAN || state == B_FLUSH,
                   "read data pending outside a scan")
  `GNTC_ASSERT_NXT(a_clear_stays, state == B_CLEAR && clr_addr != ADDR_W'(MEM_DEPTH - 1),
                   state == B_CLEAR, "clear pass ended early")

endmodule

[verif/tb_top.sv]
// Self-checking bench for grid_neighbor_type_counter: streams write and query beats,
// predicts neighbor counts from a private grid copy and compares every result beat.
// Depends on gntc_pkg and the RTL top level only.
module tb_top;
  import gntc_pkg::*;

  typedef enum logic [1:0] {CELL_NONE, CELL_O, CELL_X, CELL_K} cell_kind_t;

  typedef struct packed {
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [TYPE_W-1:0] ctype;
  } grid_op_t;

  // Packed so that empty sits in the low nibble, as on m_tdata.
  typedef struct packed {
    logic [CNT_W-1:0] occupied;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] x;
    logic [CNT_W-1:0] o;
    logic [CNT_W-1:0] empty;
  } nbr_counts_t;

  localparam logic [1:0] BND_RESERVED = 2'd3;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int ROW_STEP [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
  localparam int COL_STEP [8] = '{0, 0, -1, 1, -1, 1, -1, 1};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  s_tuser   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Shadow of the block's registers and grid.
  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] grid_cols;
  logic [1:0]        border_mode;
  logic              moore_on;
  logic [TYPE_W-1:0] grid_mem [MAX_ROWS][MAX_COLS];

  grid_op_t    pending_ops [$];
  nbr_counts_t counts_due [$];
  int          queued       = 0;
  int          accepted     = 0;
  int          fail_count   = 0;
  int          results_seen = 0;
  int          gap_left     = 0;
  int          burst_left   = 1;
  int          hold_left    = 0;
  int          stall_mode   = 0;
  int          cyc          = 0;
  string       field_name [5] = '{"empty", "o", "x", "k", "occupied"};

  grid_neighbor_type_counter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int eff_dim(input logic [SIZE_W-1:0] v, input int lim);
    if (v == '0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic nbr_counts_t count_neighbors(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    int          rows;
    int          cols;
    int          nr;
    int          nc;
    int          span;
    int          tally [4];
    nbr_counts_t res;
    rows = eff_dim(grid_rows, MAX_ROWS);
    cols = eff_dim(grid_cols, MAX_COLS);
    foreach (tally[i]) tally[i] = 0;
    if (int'(r) < rows && int'(c) < cols &&
        (border_mode == BND_CLOSED || border_mode == BND_TORUS)) begin
      span = moore_on ? 8 : 4;
      for (int n = 0; n < span; n++) begin
        nr = int'(r) + ROW_STEP[n];
        nc = int'(c) + COL_STEP[n];
        if (border_mode == BND_TORUS) begin
          // Each offset counts, even when it wraps onto a cell already seen.
          nr = (nr + rows) % rows;
          nc = (nc + cols) % cols;
          tally[grid_mem[nr][nc]]++;
        end else if (nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
          tally[grid_mem[nr][nc]]++;
        end
      end
    end
    res.empty    = CNT_W'(tally[CELL_NONE]);
    res.o        = CNT_W'(tally[CELL_O]);
    res.x        = CNT_W'(tally[CELL_X]);
    res.k        = CNT_W'(tally[CELL_K]);
    res.occupied = CNT_W'(tally[CELL_O] + tally[CELL_X] + tally[CELL_K]);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      grid_rows   <= ROWS_RESET;
      grid_cols   <= COLS_RESET;
      border_mode <= BND_CLOSED;
      moore_on    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_COUNT:     grid_rows   <= cfg_data;
        CFG_COL_COUNT:     grid_cols   <= cfg_data;
        CFG_BOUNDARY_MODE: border_mode <= cfg_data[1:0];
        CFG_MOORE_MODE:    moore_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sender: bursts of beats with random gaps; predicts on each accepted beat.
  always @(posedge clk) begin : drive_ops
    grid_op_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      foreach (grid_mem[i, j]) grid_mem[i][j] = CELL_NONE;
    end else begin
      if (s_tvalid && s_tready) begin
        accepted++;
        if (s_tuser == KIND_WRITE) begin
          if (int'(s_tdata[5:0]) < eff_dim(grid_rows, MAX_ROWS) &&
              int'(s_tdata[11:6]) < eff_dim(grid_cols, MAX_COLS))
            grid_mem[s_tdata[5:0]][s_tdata[11:6]] = s_tdata[13:12];
        end else begin
          counts_due.push_back(count_neighbors(s_tdata[5:0], s_tdata[11:6]));
        end
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          nxt = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.kind;
          s_tdata  <= {2'b00, nxt.ctype, nxt.col, nxt.row};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat; stall on a randomly chosen pattern, with two long holds.
  always @(posedge clk) begin : check_counts
    nbr_counts_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (counts_due.size() == 0) begin
          if (fail_count < 40)
            $display("%0t: result beat with none expected, got %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = counts_due.pop_front();
          for (int f = 0; f < 5; f++) begin
            if (m_tdata[4*f +: 4] !== want[4*f +: 4]) begin
              if (fail_count < 40)
                $display("%0t: %s count mismatch, expected %0d, got %0d", $time,
                         field_name[f], want[4*f +: 4], m_tdata[4*f +: 4]);
              fail_count++;
            end
          end
        end
        results_seen++;
        if (results_seen == 40 || results_seen == 500) hold_left = 400;
      end
      cyc++;
      if (cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= (cyc % 4 == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic queue_op(input logic kind, input int r, input int c,
                          input logic [TYPE_W-1:0] ctype);
    pending_ops.push_back('{kind, ROW_W'(r), COL_W'(c), ctype});
    queued++;
  endtask

  // Hold until every beat is in and every result is out, then let writes finish.
  task automatic drain();
    while (accepted != queued || counts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] rows_v, cols_v, mode_v, moore_v);
    set_reg(CFG_ROW_COUNT, rows_v);
    set_reg(CFG_COL_COUNT, cols_v);
    set_reg(CFG_BOUNDARY_MODE, mode_v);
    set_reg(CFG_MOORE_MODE, moore_v);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 7'd0;
      1:       return SIZE_W'($urandom_range(65, 127));
      2, 3:    return 7'd64;
      4, 5:    return SIZE_W'($urandom_range(9, 63));
      default: return SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic random_phase(input int n_items, input bit extreme);
    logic [SIZE_W-1:0] rows_v;
    logic [SIZE_W-1:0] cols_v;
    logic [1:0]        mode;
    logic              moore;
    int                rows;
    int                cols;
    int                r_base;
    int                c_base;
    int                r;
    int                c;
    if (extreme) begin
      rows_v = 7'd127;
      cols_v = 7'd64;
      mode   = BND_TORUS;
      moore  = 1'b1;
    end else begin
      rows_v = pick_size();
      cols_v = pick_size();
      case ($urandom_range(0, 9))
        0:       mode = BND_NONE;
        1:       mode = BND_RESERVED;
        2, 3, 4: mode = BND_CLOSED;
        default: mode = BND_TORUS;
      endcase
      moore = 1'($urandom_range(0, 1));
    end
    load_config(rows_v, cols_v, {5'($urandom), mode}, {6'($urandom), moore});
    rows = eff_dim(rows_v, MAX_ROWS);
    cols = eff_dim(cols_v, MAX_COLS);
    // Cluster beats around an anchor, often at a border so wrap and clipping both show.
    case ($urandom_range(0, 2))
      0:       begin r_base = 0; c_base = 0; end
      1:       begin r_base = (rows > 3) ? rows - 3 : 0; c_base = (cols > 3) ? cols - 3 : 0; end
      default: begin r_base = $urandom_range(0, rows - 1); c_base = $urandom_range(0, cols - 1); end
    endcase
    repeat (n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
      end else begin
        r = (r_base + $urandom_range(0, 4)) % rows;
        c = (c_base + $urandom_range(0, 4)) % cols;
      end
      queue_op(($urandom_range(0, 99) < 45) ? KIND_QUERY : KIND_WRITE, r, c,
               TYPE_W'($urandom));
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 64 x 64, closed borders, four neighbors; corners first.
    queue_op(KIND_QUERY, 0, 0, CELL_K);
    queue_op(KIND_QUERY, 63, 63, CELL_NONE);
    queue_op(KIND_WRITE, 0, 1, CELL_O);
    queue_op(KIND_WRITE, 1, 0, CELL_X);
    queue_op(KIND_WRITE, 63, 62, CELL_K);
    queue_op(KIND_WRITE, 62, 63, CELL_O);
    queue_op(KIND_WRITE, 62, 62, CELL_X);
    queue_op(KIND_QUERY, 0, 0, CELL_NONE);
    queue_op(KIND_QUERY, 63, 63, CELL_NONE);
    queue_op(KIND_QUERY, 62, 63, CELL_NONE);
    drain();

    // Zero rows reads as one, oversize columns saturate; single-row torus hits itself.
    load_config(7'd0, 7'd127, 7'h7E, 7'h01);
    queue_op(KIND_QUERY, 0, 0, CELL_NONE);
    queue_op(KIND_WRITE, 5, 3, CELL_K);
    queue_op(KIND_QUERY, 1, 0, CELL_NONE);
    queue_op(KIND_QUERY, 0, 63, CELL_NONE);
    drain();

    // 2 x 2 torus with diagonals: several offsets land on the same cell.
    load_config(7'd2, 7'd2, 7'h02, 7'h7F);
    queue_op(KIND_WRITE, 0, 0, CELL_O);
    queue_op(KIND_WRITE, 0, 1, CELL_X);
    queue_op(KIND_WRITE, 1, 0, CELL_K);
    queue_op(KIND_WRITE, 1, 1, CELL_K);
    queue_op(KIND_QUERY, 0, 0, CELL_NONE);
    queue_op(KIND_QUERY, 1, 1, CELL_NONE);
    drain();

    load_config(7'h40, 7'd64, 7'h00, 7'h00);
    queue_op(KIND_QUERY, 0, 1, CELL_NONE);
    drain();

    load_config(7'd6, 7'd0, 7'h03, 7'h01);
    queue_op(KIND_QUERY, 0, 0, CELL_NONE);
    drain();

    // Enlarged again: the earlier out-of-grid write must not have landed.
    load_config(7'd64, 7'd64, 7'h7D, 7'h01);
    queue_op(KIND_QUERY, 4, 3, CELL_NONE);
    queue_op(KIND_QUERY, 1, 1, CELL_NONE);
    drain();

    for (int p = 0; p < 15; p++) random_phase(130, p == 14);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 12);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
